// ===== hdl/obfp_pkg.sv =====
// Package for the octree best-fit path block: sizes, register indexes and
// the types shared by the level unit and the top level. No dependencies.
package obfp_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int COORD_BITS = 16;
    localparam int SCL_W      = COORD_BITS + MAX_LEVELS;
    localparam int SUM_W      = SCL_W + 1;
    localparam int OSUM_W     = COORD_BITS + 1;
    localparam int LVL_W      = $clog2(MAX_LEVELS + 1);
    localparam int IDX_W      = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int PATH_W     = 32;
    localparam int PBIT_W     = $clog2(PATH_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int DEPTH_W    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MIN_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MAX_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MAX_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WORLD_MAX_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_LIMIT = 3'd6;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [SCL_W-1:0]      t_scl;
    typedef logic signed [OSUM_W-1:0]     t_osum;

    typedef struct packed {
        logic [2:0] oct;
        logic       holds;
    } t_lvl_res;

endpackage

// ===== hdl/obfp_if.sv =====
// Handshake interfaces for the object, result and configuration channels.
// Depends on obfp_pkg for field widths.
interface obfp_obj_if import obfp_pkg::*; ;
    logic   valid;
    logic   ready;
    t_coord obj_min_x;
    t_coord obj_min_y;
    t_coord obj_min_z;
    t_coord obj_max_x;
    t_coord obj_max_y;
    t_coord obj_max_z;

    modport source (output valid, obj_min_x, obj_min_y, obj_min_z,
                    obj_max_x, obj_max_y, obj_max_z, input ready);
    modport sink   (input valid, obj_min_x, obj_min_y, obj_min_z,
                    obj_max_x, obj_max_y, obj_max_z, output ready);
endinterface

interface obfp_res_if import obfp_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [PATH_W-1:0] cell_path;
    logic [LVL_W-1:0]  levels;

    modport source (output valid, cell_path, levels, input ready);
    modport sink   (input valid, cell_path, levels, output ready);
endinterface

interface obfp_cfg_if import obfp_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/obfp_level_unit.sv =====
// One subdivision step over all three axes: picks the child octant from the
// doubled centres and tests whether that child still holds the object.
// Depends on obfp_pkg.
module obfp_level_unit
    import obfp_pkg::*;
(
    input  t_scl     i_nmin [3],
    input  t_scl     i_nmax [3],
    input  t_coord   i_omin [3],
    input  t_coord   i_omax [3],
    input  t_osum    i_osum [3],
    output t_scl     o_cmin [3],
    output t_scl     o_cmax [3],
    output t_lvl_res o_res
);

    logic signed [SUM_W-1:0] nsum [3];
    logic signed [SUM_W-1:0] osum_s [3];
    t_scl                    mid [3];
    t_scl                    omin_s [3];
    t_scl                    omax_s [3];
    logic [2:0]              ge;
    logic [2:0]              fit;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            nsum[a]   = SUM_W'(i_nmin[a]) + SUM_W'(i_nmax[a]);
            osum_s[a] = {i_osum[a], {MAX_LEVELS{1'b0}}};
            mid[a]    = nsum[a][SUM_W-1:1];
            omin_s[a] = {i_omin[a], {MAX_LEVELS{1'b0}}};
            omax_s[a] = {i_omax[a], {MAX_LEVELS{1'b0}}};
            ge[a]     = (osum_s[a] >= nsum[a]);
            o_cmin[a] = ge[a] ? mid[a] : i_nmin[a];
            o_cmax[a] = ge[a] ? i_nmax[a] : mid[a];
            fit[a]    = (o_cmin[a] <= omin_s[a]) && (omax_s[a] <= o_cmax[a]);
        end
        o_res.oct   = ge;
        o_res.holds = &fit;
    end

endmodule

// ===== hdl/octree_best_fit_path_core.sv =====
// An input transaction is captured, then descended L levels (0 to 8), one
// level per cycle by the shared level unit, and its result is then loaded
// into the output register, which can wait on o_res.ready.
// The input side is ready again once the result is in the output register.
// Reset (synchronous, active low) restores the world box and depth limit
// defaults and clears the sequencer and the output valid.
module octree_best_fit_path_core
    import obfp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    obfp_cfg_if.sink     i_cfg,
    obfp_obj_if.sink     i_obj,
    obfp_res_if.source   o_res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state;
    t_coord             r_wmin [3];
    t_coord             r_wmax [3];
    logic [DEPTH_W-1:0] r_depth_limit;

    t_coord             r_omin [3];
    t_coord             r_omax [3];
    t_osum              r_osum [3];
    t_scl               r_nmin [3];
    t_scl               r_nmax [3];
    logic               r_hold;
    logic [LVL_W-1:0]   r_limit;
    logic [LVL_W-1:0]   r_lvl;
    logic [PATH_W-1:0]  r_path;

    logic               r_out_valid;
    logic [PATH_W-1:0]  r_out_path;
    logic [LVL_W-1:0]   r_out_levels;

    t_scl               cmin [3];
    t_scl               cmax [3];
    t_lvl_res           lvl_res;
    t_coord             in_min [3];
    t_coord             in_max [3];
    logic               in_hold;
    logic               in_acc;
    logic               stop;
    logic               out_load;
    logic [LVL_W-1:0]   lvl_m1;
    logic [PBIT_W-1:0]  nib_pos;
    logic [PBIT_W-1:0]  cont_pos;
    logic [PATH_W-1:0]  n_path;

    assign i_cfg.ready = 1'b1;
    assign i_obj.ready = (r_state == S_IDLE);
    assign in_acc      = i_obj.valid && i_obj.ready;

    assign o_res.valid     = r_out_valid;
    assign o_res.cell_path = r_out_path;
    assign o_res.levels    = r_out_levels;

    assign in_min[0] = i_obj.obj_min_x;
    assign in_min[1] = i_obj.obj_min_y;
    assign in_min[2] = i_obj.obj_min_z;
    assign in_max[0] = i_obj.obj_max_x;
    assign in_max[1] = i_obj.obj_max_y;
    assign in_max[2] = i_obj.obj_max_z;

    always_comb begin
        in_hold = 1'b1;
        for (int a = 0; a < 3; a++) begin
            if (!((r_wmin[a] <= in_min[a]) && (in_max[a] <= r_wmax[a]))) begin
                in_hold = 1'b0;
            end
        end
    end

    obfp_level_unit u_level (
        .i_nmin (r_nmin),
        .i_nmax (r_nmax),
        .i_omin (r_omin),
        .i_omax (r_omax),
        .i_osum (r_osum),
        .o_cmin (cmin),
        .o_cmax (cmax),
        .o_res  (lvl_res)
    );

    assign stop     = !r_hold || (r_lvl >= r_limit) || !lvl_res.holds;
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_res.ready);
    assign lvl_m1   = r_lvl - LVL_W'(1);
    assign nib_pos  = {r_lvl[IDX_W-1:0], 2'b00};
    assign cont_pos = {lvl_m1[IDX_W-1:0], 2'b11};

    always_comb begin
        n_path = r_path;
        n_path[nib_pos +: 4] = {1'b0, lvl_res.oct};
        if (r_lvl != '0) begin
            n_path[cont_pos] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_wmin[a] <= {1'b1, {(COORD_BITS-1){1'b0}}};
                r_wmax[a] <= {1'b0, {(COORD_BITS-1){1'b1}}};
            end
            r_depth_limit <= DEPTH_W'(MAX_LEVELS);
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_WORLD_MIN_X: r_wmin[0] <= i_cfg.data[COORD_BITS-1:0];
                REG_WORLD_MIN_Y: r_wmin[1] <= i_cfg.data[COORD_BITS-1:0];
                REG_WORLD_MIN_Z: r_wmin[2] <= i_cfg.data[COORD_BITS-1:0];
                REG_WORLD_MAX_X: r_wmax[0] <= i_cfg.data[COORD_BITS-1:0];
                REG_WORLD_MAX_Y: r_wmax[1] <= i_cfg.data[COORD_BITS-1:0];
                REG_WORLD_MAX_Z: r_wmax[2] <= i_cfg.data[COORD_BITS-1:0];
                REG_DEPTH_LIMIT: r_depth_limit <= i_cfg.data[DEPTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            for (int a = 0; a < 3; a++) begin
                r_omin[a] <= in_min[a];
                r_omax[a] <= in_max[a];
                r_osum[a] <= OSUM_W'(in_min[a]) + OSUM_W'(in_max[a]);
                r_nmin[a] <= {r_wmin[a], {MAX_LEVELS{1'b0}}};
                r_nmax[a] <= {r_wmax[a], {MAX_LEVELS{1'b0}}};
            end
            r_hold  <= in_hold;
            r_limit <= (r_depth_limit > DEPTH_W'(MAX_LEVELS)) ?
                       LVL_W'(MAX_LEVELS) : LVL_W'(r_depth_limit);
            r_lvl   <= '0;
            r_path  <= '0;
        end else if (r_state == S_RUN && !stop) begin
            for (int a = 0; a < 3; a++) begin
                r_nmin[a] <= cmin[a];
                r_nmax[a] <= cmax[a];
            end
            r_path <= n_path;
            r_lvl  <= r_lvl + LVL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (stop) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out_path   <= r_path;
                        r_out_levels <= r_lvl;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_lvl_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_lvl <= r_limit))
        else $error("level count passed the depth limit");

    a_outside_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN && !r_hold) |=> (r_state == S_DONE && r_lvl == '0))
        else $error("object outside the world box was descended");

    a_root_zero_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.levels == '0) |-> (o_res.cell_path == '0))
        else $error("root result carries a nonzero path");

endmodule

// ===== tb/octree_best_fit_path_core_tb.sv =====
// Self-checking testbench for octree_best_fit_path_core: drives object boxes and
// register writes over the handshake interfaces and checks every cell path.
// Depends on obfp_pkg, the obfp_*_if interfaces and the core itself.
module octree_best_fit_path_core_tb
    import obfp_pkg::*;
;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [3:0]           STEP_MORE  = 4'h8;
    localparam int                   STUCK_LIMIT = 2000;
    localparam int                   CHUNKS = 23;
    localparam int                   CHUNK_ITEMS = 50;

    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct {
        t_coord lo[3];
        t_coord hi[3];
    } t_box;

    typedef struct {
        logic [PATH_W-1:0] cell_path;
        logic [LVL_W-1:0]  levels;
    } t_cell;

    logic clk = 1'b0;
    logic rst_n;

    obfp_cfg_if cfg_if();
    obfp_obj_if obj_if();
    obfp_res_if res_if();

    octree_best_fit_path_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_obj   (obj_if),
        .o_res   (res_if)
    );

    t_coord      world_lo[3] = '{16'sh8000, 16'sh8000, 16'sh8000};
    t_coord      world_hi[3] = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
    logic [3:0]  depth_cfg = 4'd8;

    t_box        pending_q[$];
    t_cell       placement_q[$];
    t_box        drive_box;
    t_cell       want;
    bit          obj_taken;
    bit          gap_set;
    int          gap_left;
    bit          obj_fast;
    bit          res_taken;
    int          res_stall;
    bit          res_fast;
    int          fails;
    int          boxes_sent;
    int          results_seen;
    int          settings_cnt;
    int          stuck_cycles;
    int          depth_hist[MAX_LEVELS+1];

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic t_scl scaled(t_coord c);
        return {c, {MAX_LEVELS{1'b0}}};
    endfunction

    function automatic bit holds(input t_scl blo[3], input t_scl bhi[3],
                                 input t_scl olo[3], input t_scl ohi[3]);
        for (int a = 0; a < 3; a++) begin
            if (!(blo[a] <= olo[a] && ohi[a] <= bhi[a])) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_cell place_object(t_box b);
        t_scl              olo[3], ohi[3], nlo[3], nhi[3], clo[3], chi[3];
        t_sum              osum, nsum;
        logic [2:0]        oct;
        logic [PATH_W-1:0] path;
        logic [LVL_W-1:0]  depth;
        int                lim;
        bit                go;
        t_cell             r;
        for (int a = 0; a < 3; a++) begin
            olo[a] = scaled(b.lo[a]);
            ohi[a] = scaled(b.hi[a]);
            nlo[a] = scaled(world_lo[a]);
            nhi[a] = scaled(world_hi[a]);
        end
        lim = (depth_cfg > MAX_LEVELS) ? MAX_LEVELS : depth_cfg;
        path = '0;
        depth = '0;
        go = holds(nlo, nhi, olo, ohi);
        while (go && depth < lim) begin
            oct = 3'b000;
            for (int a = 0; a < 3; a++) begin
                nsum = nlo[a] + nhi[a];
                osum = olo[a] + ohi[a];
                if (osum >= nsum) begin
                    oct[a] = 1'b1;
                    clo[a] = t_scl'(nsum >>> 1);
                    chi[a] = nhi[a];
                end else begin
                    clo[a] = nlo[a];
                    chi[a] = t_scl'(nsum >>> 1);
                end
            end
            if (holds(clo, chi, olo, ohi)) begin
                path |= PATH_W'(STEP_MORE | {1'b0, oct}) << (4 * depth);
                nlo = clo;
                nhi = chi;
                depth++;
            end else begin
                go = 1'b0;
            end
        end
        if (depth != 0) path[4 * (depth - 1) + 3] = 1'b0;
        r.cell_path = path;
        r.levels = depth;
        return r;
    endfunction

    function automatic int rand_coord();
        t_coord c;
        c = t_coord'($urandom);
        return c;
    endfunction

    function automatic int rand_in(int lo, int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    task automatic push_box(int x0, int y0, int z0, int x1, int y1, int z1);
        t_box b;
        b.lo[0] = t_coord'(x0);
        b.lo[1] = t_coord'(y0);
        b.lo[2] = t_coord'(z0);
        b.hi[0] = t_coord'(x1);
        b.hi[1] = t_coord'(y1);
        b.hi[2] = t_coord'(z1);
        pending_q = {pending_q, b};
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        cfg_if.valid <= 1'b1;
        do @(posedge clk); while (!(cfg_if.valid && cfg_if.ready));
        case (idx)
            REG_WORLD_MIN_X: world_lo[0] = val;
            REG_WORLD_MIN_Y: world_lo[1] = val;
            REG_WORLD_MIN_Z: world_lo[2] = val;
            REG_WORLD_MAX_X: world_hi[0] = val;
            REG_WORLD_MAX_Y: world_hi[1] = val;
            REG_WORLD_MAX_Z: world_hi[2] = val;
            REG_DEPTH_LIMIT: depth_cfg = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic write_depth(int d);
        logic [CFG_DATA_W-1:0] data;
        data = CFG_DATA_W'($urandom);
        data[3:0] = 4'(d);
        write_reg(REG_DEPTH_LIMIT, data);
        settings_cnt++;
    endtask

    task automatic set_world(input int lo[3], input int hi[3], input int d);
        write_reg(REG_WORLD_MIN_X, CFG_DATA_W'(lo[0]));
        write_reg(REG_WORLD_MIN_Y, CFG_DATA_W'(lo[1]));
        write_reg(REG_WORLD_MIN_Z, CFG_DATA_W'(lo[2]));
        write_reg(REG_WORLD_MAX_X, CFG_DATA_W'(hi[0]));
        write_reg(REG_WORLD_MAX_Y, CFG_DATA_W'(hi[1]));
        write_reg(REG_WORLD_MAX_Z, CFG_DATA_W'(hi[2]));
        write_depth(d);
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || obj_if.valid || placement_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic push_random(int n);
        int lo[3], hi[3];
        int wl, wh, sz, kind, t;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            for (int a = 0; a < 3; a++) begin
                wl = world_lo[a];
                wh = world_hi[a];
                if (wh < wl) begin
                    t = wl;
                    wl = wh;
                    wh = t;
                end
                sz = $urandom_range(0, (1 << $urandom_range(0, 16)) - 1);
                if (kind < 65) begin
                    lo[a] = rand_in(wl, wh);
                    hi[a] = (lo[a] + sz > wh) ? wh : lo[a] + sz;
                end else if (kind < 85) begin
                    case ($urandom_range(0, 3))
                        0: begin
                            lo[a] = wl;
                            hi[a] = (wl + sz > wh) ? wh : wl + sz;
                        end
                        1: begin
                            hi[a] = wh;
                            lo[a] = (wh - sz < wl) ? wl : wh - sz;
                        end
                        2: begin
                            lo[a] = (wl > -32768) ? wl - 1 : wl;
                            hi[a] = rand_in(wl, wh);
                        end
                        default: begin
                            lo[a] = rand_in(wl, wh);
                            hi[a] = (wh < 32767) ? wh + 1 : wh;
                        end
                    endcase
                end else begin
                    lo[a] = rand_coord();
                    hi[a] = rand_coord();
                end
            end
            push_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
        end
    endtask

    always @(negedge clk) begin
        if (!rst_n) begin
            obj_if.valid <= 1'b0;
        end else if (!obj_if.valid || obj_taken) begin
            obj_taken = 1'b0;
            if (!gap_set && pending_q.size() != 0) begin
                gap_left = obj_fast ? 0 : $urandom_range(0, 13);
                gap_set = 1'b1;
            end
            if (gap_set && gap_left == 0) begin
                drive_box = pending_q.pop_front();
                obj_if.obj_min_x <= drive_box.lo[0];
                obj_if.obj_min_y <= drive_box.lo[1];
                obj_if.obj_min_z <= drive_box.lo[2];
                obj_if.obj_max_x <= drive_box.hi[0];
                obj_if.obj_max_y <= drive_box.hi[1];
                obj_if.obj_max_z <= drive_box.hi[2];
                obj_if.valid <= 1'b1;
                gap_set = 1'b0;
            end else begin
                obj_if.valid <= 1'b0;
                if (gap_set) gap_left--;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && obj_if.valid && obj_if.ready) begin
            drive_box.lo[0] = obj_if.obj_min_x;
            drive_box.lo[1] = obj_if.obj_min_y;
            drive_box.lo[2] = obj_if.obj_min_z;
            drive_box.hi[0] = obj_if.obj_max_x;
            drive_box.hi[1] = obj_if.obj_max_y;
            drive_box.hi[2] = obj_if.obj_max_z;
            placement_q = {placement_q, place_object(drive_box)};
            obj_taken = 1'b1;
            boxes_sent++;
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                res_taken = 1'b0;
                res_stall = res_fast ? 0 : $urandom_range(0, 13);
            end
            if (res_stall > 0) begin
                res_if.ready <= 1'b0;
                res_stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) begin
            res_taken = 1'b1;
            if (placement_q.size() == 0) begin
                $error("unexpected result transaction: cell_path %h, levels %0d",
                       res_if.cell_path, res_if.levels);
                fails++;
            end else begin
                want = placement_q.pop_front();
                if (res_if.cell_path !== want.cell_path) begin
                    $error("cell_path mismatch: expected %h, got %h",
                           want.cell_path, res_if.cell_path);
                    fails++;
                end
                if (res_if.levels !== want.levels) begin
                    $error("levels mismatch: expected %0d, got %0d",
                           want.levels, res_if.levels);
                    fails++;
                end
                if (want.levels <= MAX_LEVELS) depth_hist[want.levels]++;
                results_seen++;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((obj_if.valid && obj_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", placement_q.size());
                $display("octree_best_fit_path_core_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int lo[3], hi[3];
        int a_v, b_v, mode, d;
        rst_n = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data = '0;
        obj_if.valid = 1'b0;
        obj_if.obj_min_x = '0;
        obj_if.obj_min_y = '0;
        obj_if.obj_min_z = '0;
        obj_if.obj_max_x = '0;
        obj_if.obj_max_y = '0;
        obj_if.obj_max_z = '0;
        res_if.ready = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Writes to the unused index must leave the configuration untouched.
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

        push_box(0, 0, 0, 0, 0, 0);
        push_box(-32768, -32768, -32768, -32768, -32768, -32768);
        push_box(32767, 32767, 32767, 32767, 32767, 32767);
        push_box(-32768, -32768, -32768, 32767, 32767, 32767);
        push_box(100, 100, 100, -100, -100, -100);
        push_box(-1, -1, -1, 0, 0, 0);
        for (int o = 0; o < 8; o++) begin
            push_box(o[0] ? 20000 : -20000, o[1] ? 20000 : -20000, o[2] ? 20000 : -20000,
                     o[0] ? 20005 : -19995, o[1] ? 20005 : -19995, o[2] ? 20005 : -19995);
        end
        wait_drained();

        set_world('{-1000, -2000, -3000}, '{1000, 2000, 3000}, 3);
        push_box(-1001, 0, 0, 0, 0, 0);
        push_box(0, 0, 0, 0, 0, 3001);
        push_box(-1000, -2000, -3000, 1000, 2000, 3000);
        push_box(500, 500, 500, 501, 501, 501);
        wait_drained();
        write_depth(0);
        push_box(7, 7, 7, 7, 7, 7);
        wait_drained();
        write_depth(15);
        push_box(7, 7, 7, 7, 7, 7);
        wait_drained();

        for (int k = 0; k < CHUNKS; k++) begin
            mode = k % 6;
            d = 8;
            for (int a = 0; a < 3; a++) begin
                a_v = rand_coord();
                b_v = rand_coord();
                lo[a] = (a_v < b_v) ? a_v : b_v;
                hi[a] = (a_v < b_v) ? b_v : a_v;
            end
            case (mode)
                0: begin
                    lo = '{-32768, -32768, -32768};
                    hi = '{32767, 32767, 32767};
                    d = $urandom_range(0, 15);
                end
                2: begin
                    for (int a = 0; a < 3; a++) begin
                        lo[a] = rand_in(-32768, 32700);
                        hi[a] = lo[a] + $urandom_range(0, 40);
                    end
                    d = $urandom_range(1, 8);
                end
                3: begin
                    if (k == 3) hi = lo;
                    d = $urandom_range(9, 15);
                end
                4: begin
                    lo = '{-32768, -32768, -32768};
                    hi = '{32767, 32767, 32767};
                end
                5: begin
                    if (k == 5) begin
                        lo[0] = 32767;
                        hi[0] = -32768;
                    end
                    d = $urandom_range(0, 8);
                end
                default: ;
            endcase
            set_world(lo, hi, d);
            obj_fast = (k % 4 == 3) || ($urandom_range(0, 5) == 0);
            res_fast = (k % 4 == 3) || ($urandom_range(0, 5) == 0);
            push_random(CHUNK_ITEMS);
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("%0d object boxes placed under %0d world/depth settings, %0d results checked",
                 boxes_sent, settings_cnt, results_seen);
        $display("results per descent depth 0..%0d: %p", MAX_LEVELS, depth_hist);
        if (fails == 0) begin
            $display("octree_best_fit_path_core_tb: PASS");
        end else begin
            $display("octree_best_fit_path_core_tb: FAIL");
        end
        $finish;
    end

endmodule
